// ===== rtl/etc_pkg.sv =====
// Package for the English text classifier: constants, character classes and verdict codes.
`timescale 1ns / 1ps
package etc_pkg;

  localparam int unsigned MaxBytesDef = 1024;
  localparam int unsigned CfgW        = 11;
  localparam logic [CfgW-1:0] MinLengthRst = 11'd50;

  localparam int unsigned ByteW = 8;
  localparam int unsigned OutDataW = 8;

  // Raw and folded characters of interest
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChNl     = 8'h0A;
  localparam logic [ByteW-1:0] ChFold   = 8'h20;
  localparam logic [ByteW-1:0] ChA      = 8'h61;
  localparam logic [ByteW-1:0] ChE      = 8'h65;
  localparam logic [ByteW-1:0] ChI      = 8'h69;
  localparam logic [ByteW-1:0] ChO      = 8'h6F;
  localparam logic [ByteW-1:0] ChU      = 8'h75;
  localparam logic [ByteW-1:0] ChT      = 8'h74;
  localparam logic [ByteW-1:0] ChN      = 8'h6E;
  localparam logic [ByteW-1:0] ChV      = 8'h76;
  localparam logic [ByteW-1:0] ChJ      = 8'h6A;
  localparam logic [ByteW-1:0] ChK      = 8'h6B;
  localparam logic [ByteW-1:0] ChQ      = 8'h71;
  localparam logic [ByteW-1:0] ChX      = 8'h78;
  localparam logic [ByteW-1:0] ChZ      = 8'h7A;
  localparam logic [ByteW-1:0] ChSemi   = 8'h3B;
  localparam logic [ByteW-1:0] ChGt     = 8'h3E;
  localparam logic [ByteW-1:0] ChLt     = 8'h3C;
  localparam logic [ByteW-1:0] ChSlash  = 8'h2F;
  localparam logic [ByteW-1:0] ChDot    = 8'h2E;
  localparam logic [ByteW-1:0] ChComma  = 8'h2C;
  localparam logic [ByteW-1:0] ChRParen = 8'h29;
  localparam logic [ByteW-1:0] ChPct    = 8'h25;
  localparam logic [ByteW-1:0] ChColon  = 8'h3A;
  localparam logic [ByteW-1:0] ChQuest  = 8'h3F;

  typedef enum logic [2:0] {
    R_ENGLISH   = 3'd0,
    R_SHORT     = 3'd1,
    R_BAD_PUNCT = 3'd2,
    R_SEMI      = 3'd3,
    R_MARKUP    = 3'd4,
    R_STATS     = 3'd5
  } reason_t;

  // Per-byte class flags; one byte may raise several
  typedef struct packed {
    logic vowel;
    logic e;
    logic freq;
    logic rare;
    logic semi;
    logic markup;
    logic space;
    logic punct;
    logic sep;
  } char_class_t;

endpackage

// ===== rtl/etc_decode.sv =====
// Byte decoder: folds a byte and raises the class flags it belongs to.
`timescale 1ns / 1ps
module etc_decode (
  input  logic [etc_pkg::ByteW-1:0] text_byte,
  output etc_pkg::char_class_t      cls
);
  import etc_pkg::*;

  logic [ByteW-1:0] fold;
  logic             low;

  always_comb begin
    fold = text_byte | ChFold;
    low  = ~text_byte[ByteW-1];
    cls.vowel  = low && (fold == ChA || fold == ChE || fold == ChI ||
                         fold == ChO || fold == ChU);
    cls.e      = low && (fold == ChE);
    cls.freq   = low && (fold == ChE || fold == ChT || fold == ChA ||
                         fold == ChI || fold == ChO || fold == ChN);
    cls.rare   = low && (fold == ChV || fold == ChJ || fold == ChK ||
                         fold == ChQ || fold == ChX || fold == ChZ);
    cls.semi   = low && (fold == ChSemi);
    cls.markup = low && (fold == ChGt || fold == ChLt || fold == ChSlash);
    // the NUL byte folds onto space too
    cls.space  = low && (fold == ChSpace);
    // punctuation and separators look at the raw byte
    cls.punct  = text_byte == ChDot || text_byte == ChComma || text_byte == ChRParen ||
                 text_byte == ChPct || text_byte == ChSemi || text_byte == ChColon ||
                 text_byte == ChQuest;
    cls.sep    = text_byte == ChSpace || text_byte == ChNl;
  end

endmodule

// ===== rtl/english_text_classifier.sv =====
// Top level of the English text classifier: byte counters and verdict logic.
//
// Channel  Dir  Ports                                  Contents
// in       in   in_tvalid/in_tready/in_tdata/in_tlast  text_byte [7:0]; in_tlast = last
// out      out  out_tvalid/out_tready/out_tdata        is_english [0], verdict_reason [3:1]
// cfg      in   cfg_we/cfg_wdata                       min_length [10:0]
//
// One byte per cycle is taken unless a last byte waits for the output; each byte passes
// through the input register, and the verdict of a last byte is registered in the output
// register when that byte leaves the input register.
// Reset sets min_length to 50 and clears all counters; counters clear again after
// each verdict. A stalled verdict holds only a following last byte; other bytes
// keep flowing through the counters.
`timescale 1ns / 1ps
module english_text_classifier #(
  parameter int unsigned MAX_BYTES = etc_pkg::MaxBytesDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [etc_pkg::ByteW-1:0]    in_tdata,   // text_byte [7:0]
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [etc_pkg::OutDataW-1:0] out_tdata,  // is_english [0], verdict_reason [3:1]
  input  logic                         cfg_we,
  input  logic [etc_pkg::CfgW-1:0]     cfg_wdata   // min_length [10:0]
);
  import etc_pkg::*;

  localparam int unsigned BW = $clog2(MAX_BYTES + 1);
  localparam int unsigned JW = BW + 4;
  localparam logic [BW-1:0] MaxCnt = BW'(MAX_BYTES);

  logic [CfgW-1:0]  min_len_r;

  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_last_r;
  logic             s1_go;
  logic             s1_fire;
  char_class_t      cls;

  logic [BW-1:0] byte_r, byte_upd, byte_nxt;
  logic [BW-1:0] punct_r, punct_upd, punct_nxt;
  logic [BW-1:0] bad_r, bad_upd, bad_nxt;
  logic          pend_r, pend_upd, pend_nxt;
  logic [BW-1:0] vow_r, vow_upd, vow_nxt;
  logic [BW-1:0] e_r, e_upd, e_nxt;
  logic [BW-1:0] freq_r, freq_upd, freq_nxt;
  logic [BW-1:0] rare_r, rare_upd, rare_nxt;
  logic [BW-1:0] semi_r, semi_upd, semi_nxt;
  logic [BW-1:0] mark_r, mark_upd, mark_nxt;
  logic [BW-1:0] space_r, space_upd, space_nxt;
  logic          take;

  logic [JW-1:0] n_x, min_x, bad5, punct_x, semi2, e_x, mark_x, vow5sp, freq_x, rare10;
  reason_t       reason;

  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r;

  etc_decode u_decode (
    .text_byte (s1_byte_r),
    .cls       (cls)
  );

  // a last byte waits for a free output slot
  assign s1_go     = ~s1_last_r || ~out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_go;
  assign in_tready = ~s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MinLengthRst;
    end else if (cfg_we) begin
      min_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_comb begin
    take      = s1_fire && (byte_r < MaxCnt);
    byte_upd  = byte_r;
    punct_upd = punct_r;
    bad_upd   = bad_r;
    pend_upd  = pend_r;
    vow_upd   = vow_r;
    e_upd     = e_r;
    freq_upd  = freq_r;
    rare_upd  = rare_r;
    semi_upd  = semi_r;
    mark_upd  = mark_r;
    space_upd = space_r;
    if (take) begin
      byte_upd  = byte_r + BW'(1);
      punct_upd = punct_r + BW'(cls.punct);
      bad_upd   = bad_r + BW'(pend_r && !cls.sep);
      pend_upd  = cls.punct;
      vow_upd   = vow_r + BW'(cls.vowel);
      e_upd     = e_r + BW'(cls.e);
      freq_upd  = freq_r + BW'(cls.freq);
      rare_upd  = rare_r + BW'(cls.rare);
      semi_upd  = semi_r + BW'(cls.semi);
      mark_upd  = mark_r + BW'(cls.markup);
      space_upd = space_r + BW'(cls.space);
    end

    // clear everything once the verdict is registered
    if (s1_fire && s1_last_r) begin
      byte_nxt  = '0;
      punct_nxt = '0;
      bad_nxt   = '0;
      pend_nxt  = 1'b0;
      vow_nxt   = '0;
      e_nxt     = '0;
      freq_nxt  = '0;
      rare_nxt  = '0;
      semi_nxt  = '0;
      mark_nxt  = '0;
      space_nxt = '0;
    end else begin
      byte_nxt  = byte_upd;
      punct_nxt = punct_upd;
      bad_nxt   = bad_upd;
      pend_nxt  = pend_upd;
      vow_nxt   = vow_upd;
      e_nxt     = e_upd;
      freq_nxt  = freq_upd;
      rare_nxt  = rare_upd;
      semi_nxt  = semi_upd;
      mark_nxt  = mark_upd;
      space_nxt = space_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r  <= '0;
      punct_r <= '0;
      bad_r   <= '0;
      pend_r  <= 1'b0;
      vow_r   <= '0;
      e_r     <= '0;
      freq_r  <= '0;
      rare_r  <= '0;
      semi_r  <= '0;
      mark_r  <= '0;
      space_r <= '0;
    end else begin
      byte_r  <= byte_nxt;
      punct_r <= punct_nxt;
      bad_r   <= bad_nxt;
      pend_r  <= pend_nxt;
      vow_r   <= vow_nxt;
      e_r     <= e_nxt;
      freq_r  <= freq_nxt;
      rare_r  <= rare_nxt;
      semi_r  <= semi_nxt;
      mark_r  <= mark_nxt;
      space_r <= space_nxt;
    end
  end

  // verdict on the counts including the current byte
  always_comb begin
    n_x     = JW'(byte_upd);
    min_x   = JW'(min_len_r);
    punct_x = JW'(punct_upd);
    bad5    = (JW'(bad_upd) << 2) + JW'(bad_upd);
    semi2   = JW'(semi_upd) << 1;
    e_x     = JW'(e_upd);
    mark_x  = JW'(mark_upd);
    vow5sp  = (JW'(vow_upd) << 2) + JW'(vow_upd) + JW'(space_upd);
    freq_x  = JW'(freq_upd);
    rare10  = (JW'(rare_upd) << 3) + (JW'(rare_upd) << 1);
    if (n_x < min_x) begin
      reason = R_SHORT;
    end else if (bad5 > punct_x) begin
      reason = R_BAD_PUNCT;
    end else if (semi2 > e_x) begin
      reason = R_SEMI;
    end else if (mark_x > e_x) begin
      reason = R_MARKUP;
    end else if (vow5sp >= n_x && freq_x >= rare10) begin
      reason = R_ENGLISH;
    end else begin
      reason = R_STATS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_data_r <= {{(OutDataW - 4){1'b0}}, reason, reason == R_ENGLISH};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
